/* design/hpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hpc_pkg;
  localparam int unsigned DataW = 32;

  typedef enum logic {
    OP_NARROW = 1'b0,
    OP_WIDEN  = 1'b1
  } op_t;

  // Stage 1 classification result
  typedef enum logic [2:0] {
    CL_TINY   = 3'd0,
    CL_NAN    = 3'd1,
    CL_INF    = 3'd2,
    CL_NORM   = 3'd3,
    CL_WZERO  = 3'd4,
    CL_WSUB   = 3'd5,
    CL_WSPEC  = 3'd6,
    CL_WNORM  = 3'd7
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        sign;
    logic [30:0] mag;
  } s1_t;

  typedef struct packed {
    cls_t        cls;
    logic        sign;
    logic [30:0] mag;
    logic [4:0]  shamt;
  } s2_t;
endpackage
`default_nettype wire

/* design/hpc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface hpc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] operand;
  modport source (output valid, opcode, operand, input ready);
  modport sink (input valid, opcode, operand, output ready);
endinterface

interface hpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] converted;
  modport source (output valid, converted, input ready);
  modport sink (input valid, converted, output ready);
endinterface
`default_nettype wire

/* design/hpc_classify.sv */
`timescale 1ns / 1ps
`default_nettype none
module hpc_classify (
  input  wire logic        opcode,
  input  wire logic [31:0] operand,
  output hpc_pkg::s1_t     s1
);
  logic [30:0] mag32;
  logic [14:0] mag16;

  // Sort the operand into the special cases of each direction
  always_comb begin
    mag32 = operand[30:0];
    mag16 = operand[14:0];
    s1 = '0;
    if (opcode == hpc_pkg::OP_NARROW) begin
      s1.sign = operand[31];
      s1.mag = mag32;
      if (mag32 < 31'h38800000) s1.cls = hpc_pkg::CL_TINY;
      else if (mag32 > 31'h7F800000) s1.cls = hpc_pkg::CL_NAN;
      else if (mag32 > 31'h477FE000) s1.cls = hpc_pkg::CL_INF;
      else s1.cls = hpc_pkg::CL_NORM;
    end else begin
      s1.sign = operand[15];
      s1.mag = {16'd0, mag16};
      if (mag16 == 15'd0) s1.cls = hpc_pkg::CL_WZERO;
      else if (mag16 <= 15'h03FF) s1.cls = hpc_pkg::CL_WSUB;
      else if (mag16 >= 15'h7C00) s1.cls = hpc_pkg::CL_WSPEC;
      else s1.cls = hpc_pkg::CL_WNORM;
    end
  end
endmodule
`default_nettype wire

/* design/hpc_shift_calc.sv */
`timescale 1ns / 1ps
`default_nettype none
module hpc_shift_calc (
  input  wire hpc_pkg::s1_t s1,
  output hpc_pkg::s2_t      s2
);
  logic [7:0] e;
  logic [8:0] sh;
  logic [3:0] p;

  // Work out the shift amount: right shift for tiny narrowing, leading one for widening subnormals
  always_comb begin
    e = s1.mag[30:23];
    sh = 9'd126 - {1'b0, e};
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (s1.mag[i]) p = 4'(i);
    end
    s2.cls = s1.cls;
    s2.sign = s1.sign;
    s2.mag = s1.mag;
    s2.shamt = 5'd0;
    if (s1.cls == hpc_pkg::CL_TINY) begin
      if (e == 8'd0 || sh >= 9'd32) s2.shamt = 5'd31;
      else s2.shamt = sh[4:0];
      if (e == 8'd0) s2.mag = '0;
    end else if (s1.cls == hpc_pkg::CL_WSUB) begin
      s2.shamt = {1'b0, p};
    end
  end
endmodule
`default_nettype wire

/* design/hpc_assemble.sv */
`timescale 1ns / 1ps
`default_nettype none
module hpc_assemble (
  input  wire hpc_pkg::s2_t s2,
  output logic [31:0]       converted
);
  logic [23:0] sig;
  logic [15:0] h;
  logic [30:0] m;
  logic [31:0] r;
  logic [22:0] wm;

  // Build the final pattern for each class
  always_comb begin
    sig = {1'b1, s2.mag[22:0]};
    m = (s2.mag < 31'h7F802000) ? 31'h7F802000 : s2.mag;
    h = '0;
    r = '0;
    wm = {13'd0, s2.mag[9:0]} << (5'd23 - s2.shamt);
    case (s2.cls)
      hpc_pkg::CL_TINY:  h = {s2.sign, 15'(24'(sig >> s2.shamt))};
      hpc_pkg::CL_NAN:   h = {s2.sign, 15'(m[30:13] - 18'h38000)};
      hpc_pkg::CL_INF:   h = {s2.sign, 15'h7C00};
      hpc_pkg::CL_NORM:  h = {s2.sign, 15'(s2.mag[30:13] - 18'h1C000)};
      hpc_pkg::CL_WZERO: r = {s2.sign, 31'd0};
      hpc_pkg::CL_WSUB:  r = {s2.sign, 8'(s2.shamt) + 8'd103, wm};
      hpc_pkg::CL_WSPEC: r = {s2.sign, 31'({16'd0, s2.mag[14:0]} + 31'h38000) << 13};
      hpc_pkg::CL_WNORM: r = {s2.sign, 31'({16'd0, s2.mag[14:0]} + 31'h1C000) << 13};
      default:           r = '0;
    endcase
    if (s2.cls == hpc_pkg::CL_TINY && s2.mag == '0) h = {s2.sign, 15'd0};
    if (s2.cls == hpc_pkg::CL_TINY || s2.cls == hpc_pkg::CL_NAN ||
        s2.cls == hpc_pkg::CL_INF || s2.cls == hpc_pkg::CL_NORM) begin
      converted = {16'd0, h};
    end else begin
      converted = r;
    end
  end
endmodule
`default_nettype wire

/* design/half_precision_converter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Single/half precision bit-pattern converter.
// in: opcode (0 narrow single to half, 1 widen half to single) and a 32-bit
// operand; a half operand uses bits 15..0. out: a 32-bit converted pattern,
// a half result zero-extended in bits 15..0.
// Both channels use valid/ready; a beat moves when both are high.
// An accepted input beat passes through the classify, shift-amount and
// assemble stages, each ending in a register, before it reaches out_valid.
// Throughput: one beat per cycle; a new beat enters every cycle while the
// output is taken.
// Stall: when out_ready is low, a stage holds if the one after it is full;
// in_ready drops only when the whole pipe is full. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload
// registers are not reset.
module half_precision_converter_core (
  input wire logic clk,
  input wire logic rst_n,
  hpc_in_if.sink   in_ch,
  hpc_out_if.source out_ch
);
  hpc_pkg::s1_t s1_c, s1_r;
  hpc_pkg::s2_t s2_c, s2_r;
  logic [31:0]  cv_c, cv_r;
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  // Advance a stage when it is empty or its contents move on
  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  hpc_classify u_cls (.opcode(in_ch.opcode), .operand(in_ch.operand), .s1(s1_c));
  hpc_shift_calc u_sh (.s1(s1_r), .s2(s2_c));
  hpc_assemble u_asm (.s2(s2_r), .converted(cv_c));

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_c;
    if (en2) s2_r <= s2_c;
    if (en3) cv_r <= cv_c;
  end

  assign out_ch.valid = v3_r;
  assign out_ch.converted = cv_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_ch.ready |=> v3_r && $stable(cv_r)) else $error("output beat dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r && v2_r && v3_r) else $error("stall without full pipe");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r) else $error("accepted beat lost");
`endif
endmodule
`default_nettype wire

/* verif/hpc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module hpc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_operand,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_converted,
  output int               fail_count,
  output int               pending
);
  logic [31:0] expected_q[$];

  // Narrow a single pattern to half, truncating toward zero; above 0x477FE000 becomes infinity
  function automatic logic [31:0] to_half(input logic [31:0] x);
    logic [15:0] sgn;
    logic [30:0] mag;
    logic [7:0]  e;
    logic [31:0] h;
    sgn = {x[31], 15'd0};
    mag = x[30:0];
    e = mag[30:23];
    if (mag < 31'h3880_0000) begin
      if (e == 8'd0 || (126 - e) >= 32) h = 32'd0;
      else h = {8'd0, 1'b1, mag[22:0]} >> (126 - e);
    end else if (mag > 31'h7F80_0000) begin
      if (mag < 31'h7F80_2000) mag = 31'h7F80_2000;
      h = ({1'b0, mag} >> 13) - 32'h38000;
    end else if (mag > 31'h477F_E000) begin
      h = 32'h7C00;
    end else begin
      h = ({1'b0, mag} >> 13) - 32'h1C000;
    end
    return {16'd0, h[15:0] | sgn};
  endfunction

  // Widen a half pattern to single, exactly
  function automatic logic [31:0] to_single(input logic [15:0] x);
    logic [14:0] mag;
    logic [31:0] r;
    int p;
    mag = x[14:0];
    if (mag == 15'd0) begin
      r = 32'd0;
    end else if (mag <= 15'h03FF) begin
      p = 9;
      while (!mag[p]) p--;
      r = ((p + 103) << 23) | (({17'd0, mag} << (23 - p)) & 32'h7F_FFFF);
    end else if (mag >= 15'h7C00) begin
      r = ({17'd0, mag} + 32'h38000) << 13;
    end else begin
      r = ({17'd0, mag} + 32'h1C000) << 13;
    end
    return r | {x[15], 31'd0};
  endfunction

  // Predict on each input beat, compare on each output beat
  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_opcode == hpc_pkg::OP_NARROW) expected_q.push_back(to_half(in_operand));
        else expected_q.push_back(to_single(in_operand[15:0]));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat: %h", out_converted);
          fail_count <= fail_count + 1;
        end else begin
          if (expected_q[0] !== out_converted) begin
            if (fail_count < 10)
              $display("mismatch: expected %h, got %h", expected_q[0], out_converted);
            fail_count <= fail_count + 1;
          end
          void'(expected_q.pop_front());
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  hpc_in_if  in_ch ();
  hpc_out_if out_ch ();

  half_precision_converter_core uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  hpc_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_opcode(in_ch.opcode), .in_operand(in_ch.operand),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_converted(out_ch.converted),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop out_ready for a randomly drawn gap before each beat
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid);
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input logic [31:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.operand <= val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random single: mostly interesting exponents
  function automatic logic [31:0] rand_single();
    logic [7:0] e;
    case ($urandom_range(0, 5))
      0: e = 8'd0;
      1: e = 8'hFF;
      2: e = 8'($urandom_range(100, 115));
      3: e = 8'($urandom_range(140, 145));
      4: e = 8'($urandom_range(0, 255));
      default: e = 8'($urandom_range(112, 142));
    endcase
    return {$urandom_range(0, 1) == 1, e, 23'($urandom)};
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [31:0] halves[$];
    int wait_cnt;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = hpc_pkg::OP_NARROW;
    in_ch.operand = 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Narrowing: zeros, overflow edge, tiny, subnormal, inf, NaN floor
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h477F_E000, 32'h477F_FFFF,
                 32'h477F_E001, 32'hC780_0000, 32'h3880_0000, 32'h387F_FFFF,
                 32'h3380_0000, 32'h337F_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F80_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h7FC0_0000};
    foreach (directed[i]) send_beat(hpc_pkg::OP_NARROW, directed[i]);
    // Widening: zero, subnormal extremes, max, inf, NaN, junk upper bits
    halves = '{32'h0000_8000, 32'h0000_0001, 32'hFFFF_03FF, 32'h0000_0400,
               32'h0000_7BFF, 32'h0000_FC00, 32'hABCD_7C01, 32'h0000_FFFF};
    foreach (halves[i]) send_beat(hpc_pkg::OP_WIDEN, halves[i]);

    repeat (1900) begin
      if ($urandom_range(0, 1) == 0) send_beat(hpc_pkg::OP_NARROW, rand_single());
      else send_beat(hpc_pkg::OP_WIDEN, $urandom);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
